/* rtl/ced_pkg.sv */
// Package for the C escape sequence decoder: field widths, phase and
// status codes, character constants and the character classifiers.
// No dependencies.
package ced_pkg;

  // Field widths
  localparam int CH_W          = 8;
  localparam int VAL_W         = 32;
  localparam int STATUS_W      = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int VALUE_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

  // Reset values of the range registers
  localparam logic [VAL_W-1:0] RANGE_LOW_RST  = 32'd0;
  localparam logic [VAL_W-1:0] RANGE_HIGH_RST = 32'd255;

  // Decoder phases
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_OCTAL     = 2'd1;
  localparam logic [1:0] PH_HEX_FIRST = 2'd2;
  localparam logic [1:0] PH_HEX_MORE  = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_HEX_EMPTY      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNEXPECTED_END = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNIVERSAL      = 3'd5;

  // Octal escapes keep eight bits and stop after this many digits
  localparam int            OCT_KEEP_W  = 8;
  localparam logic [1:0]    OCT_MAX_DIG = 2'd3;

  // Character constants
  localparam logic [CH_W-1:0] CH_QUOTE  = 8'h27;
  localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_A      = 8'h61;
  localparam logic [CH_W-1:0] CH_B      = 8'h62;
  localparam logic [CH_W-1:0] CH_F      = 8'h66;
  localparam logic [CH_W-1:0] CH_N      = 8'h6E;
  localparam logic [CH_W-1:0] CH_R      = 8'h72;
  localparam logic [CH_W-1:0] CH_T      = 8'h74;
  localparam logic [CH_W-1:0] CH_V      = 8'h76;
  localparam logic [CH_W-1:0] CH_X      = 8'h78;
  localparam logic [CH_W-1:0] CH_LOW_U  = 8'h75;
  localparam logic [CH_W-1:0] CH_UP_U   = 8'h55;
  localparam logic [CH_W-1:0] CH_0      = 8'h30;
  localparam logic [CH_W-1:0] CH_7      = 8'h37;
  localparam logic [CH_W-1:0] CH_9      = 8'h39;
  localparam logic [CH_W-1:0] CH_LOW_AA = 8'h61;
  localparam logic [CH_W-1:0] CH_LOW_FF = 8'h66;
  localparam logic [CH_W-1:0] CH_UP_AA  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_FF  = 8'h46;

  // Control codes of the simple escapes
  localparam logic [CH_W-1:0] CODE_BEL = 8'h07;
  localparam logic [CH_W-1:0] CODE_BS  = 8'h08;
  localparam logic [CH_W-1:0] CODE_FF  = 8'h0C;
  localparam logic [CH_W-1:0] CODE_LF  = 8'h0A;
  localparam logic [CH_W-1:0] CODE_CR  = 8'h0D;
  localparam logic [CH_W-1:0] CODE_HT  = 8'h09;
  localparam logic [CH_W-1:0] CODE_VT  = 8'h0B;

  typedef struct packed {
    logic             hit;
    logic [CH_W-1:0]  code;
  } simple_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] dig;
  } hex_t;

  // Simple escape letter to its code
  function automatic simple_t simple_code(input logic [CH_W-1:0] c);
    simple_t r;
    r.hit  = 1'b1;
    r.code = c;
    case (c)
      CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: r.code = c;
      CH_A:    r.code = CODE_BEL;
      CH_B:    r.code = CODE_BS;
      CH_F:    r.code = CODE_FF;
      CH_N:    r.code = CODE_LF;
      CH_R:    r.code = CODE_CR;
      CH_T:    r.code = CODE_HT;
      CH_V:    r.code = CODE_VT;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // Hex digit classifier
  function automatic hex_t hex_digit(input logic [CH_W-1:0] c);
    hex_t r;
    logic [CH_W-1:0] t;
    r.hit = 1'b0;
    r.dig = 4'd0;
    t     = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t     = c - CH_0;
      r.hit = 1'b1;
      r.dig = t[3:0];
    end else if (c >= CH_LOW_AA && c <= CH_LOW_FF) begin
      t     = c - CH_LOW_AA + 8'd10;
      r.hit = 1'b1;
      r.dig = t[3:0];
    end else if (c >= CH_UP_AA && c <= CH_UP_FF) begin
      t     = c - CH_UP_AA + 8'd10;
      r.hit = 1'b1;
      r.dig = t[3:0];
    end
    return r;
  endfunction

endpackage

/* rtl/ced_in_if.sv */
// Input channel of the escape decoder: one source character per word.
// Depends on ced_pkg.
interface ced_in_if
  import ced_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            at_end;

  modport source (output valid, output ch, output at_end, input ready);
  modport sink   (input valid, input ch, input at_end, output ready);
endinterface

/* rtl/ced_out_if.sv */
// Result channel of the escape decoder: one decode result per word.
// Depends on ced_pkg.
interface ced_out_if
  import ced_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                done_res;
  logic                consumed;
  logic [VAL_W-1:0]    value;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output done_res, output consumed, output value,
                  output status, input ready);
  modport sink   (input valid, input done_res, input consumed, input value,
                  input status, output ready);
endinterface

/* rtl/c_escape_sequence_decoder_unit.sv */
// C escape sequence decoder, top level: input register, decode logic,
// result register. Depends on ced_pkg, ced_in_if and ced_out_if.
//
//  channel   dir  payload                              handshake
//  in_chan   in   ch[7:0], at_end                      valid/ready
//  out_chan  out  done_res, consumed, value[31:0],     valid/ready
//                 status[2:0]
//  cfg_*     in   cfg_idx (0 range_low, 1 range_high), cfg_we, no ready
//                 cfg_wdata[31:0]
//
// One word per cycle sustained while out_chan takes results. Each accepted
// word is loaded into the input register and then decoded into the result
// register, which drives out_chan.
// The escape state (phase, digit count, accumulator, overflow) advances in the
// same cycle the result is registered, so consecutive characters flow freely.
// rst_n is synchronous: both stages empty, decoder idle, ranges 0..255.
// A stalled result holds both stages; input is taken whenever the input
// register is empty or moves forward.
module c_escape_sequence_decoder_unit
  import ced_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ced_in_if.sink               in_chan,
  ced_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [VAL_W-1:0]     cfg_wdata
);

  // Configuration registers
  logic [VAL_W-1:0] range_low_r, range_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RANGE_LOW:  range_low_r  <= cfg_wdata;
        REG_RANGE_HIGH: range_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic            in_vld_r, out_vld_r;
  logic [CH_W-1:0] in_ch_r;
  logic            in_end_r;
  logic            advance;

  assign advance       = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_ch_r  <= in_chan.ch;
      in_end_r <= in_chan.at_end;
    end
  end

  // Escape state
  logic [1:0]             phase_r, phase_nxt;
  logic [1:0]             dcnt_r, dcnt_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   ovf_r, ovf_nxt;

  // Result fields
  logic                done_nxt, used_nxt;
  logic [VAL_W-1:0]    val_nxt;
  logic [STATUS_W-1:0] st_nxt;

  logic                done_r, used_r;
  logic [VAL_W-1:0]    val_r;
  logic [STATUS_W-1:0] st_r;

  // Decode helpers
  simple_t                smp;
  hex_t                   hx;
  logic                   oct_hit;
  logic [2:0]             oct_dig;
  logic [OCT_KEEP_W+2:0]  oct_v;
  logic                   fin_val;
  logic [VAL_W-1:0]       fin_ext;
  logic [VALUE_WIDTH-1:0] fin_acc;
  logic [1:0]             dcnt_inc;

  assign smp     = simple_code(in_ch_r);
  assign hx      = hex_digit(in_ch_r);
  assign oct_hit = !in_end_r && in_ch_r >= CH_0 && in_ch_r <= CH_7;
  assign oct_dig = in_ch_r[2:0];
  assign oct_v   = {acc_r[OCT_KEEP_W-1:0], oct_dig};
  assign dcnt_inc = dcnt_r + 2'd1;

  // Next state and result
  always_comb begin
    phase_nxt = phase_r;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    done_nxt  = 1'b0;
    used_nxt  = 1'b1;
    val_nxt   = '0;
    st_nxt    = ST_OK;
    fin_val   = 1'b0;
    fin_acc   = acc_r;
    case (phase_r)
      PH_IDLE: begin
        if (in_end_r) begin
          done_nxt = 1'b1;
          used_nxt = 1'b0;
          st_nxt   = ST_UNEXPECTED_END;
        end else if (smp.hit) begin
          fin_val = 1'b1;
          fin_acc = VALUE_WIDTH'(smp.code);
        end else if (oct_hit) begin
          acc_nxt   = VALUE_WIDTH'(oct_dig);
          dcnt_nxt  = 2'd1;
          phase_nxt = PH_OCTAL;
        end else if (in_ch_r == CH_X) begin
          phase_nxt = PH_HEX_FIRST;
        end else if (in_ch_r == CH_LOW_U || in_ch_r == CH_UP_U) begin
          done_nxt = 1'b1;
          st_nxt   = ST_UNIVERSAL;
        end else begin
          done_nxt = 1'b1;
          st_nxt   = ST_UNKNOWN;
        end
      end
      PH_OCTAL: begin
        if (!oct_hit) begin
          // terminator is handed back
          fin_val  = 1'b1;
          used_nxt = 1'b0;
        end else begin
          if (oct_v[OCT_KEEP_W+2:OCT_KEEP_W] != 3'd0) ovf_nxt = 1'b1;
          acc_nxt  = VALUE_WIDTH'(oct_v[OCT_KEEP_W-1:0]);
          dcnt_nxt = dcnt_inc;
          if (dcnt_inc == OCT_MAX_DIG) begin
            fin_val = 1'b1;
            fin_acc = VALUE_WIDTH'(oct_v[OCT_KEEP_W-1:0]);
          end
        end
      end
      PH_HEX_FIRST: begin
        if (in_end_r || !hx.hit) begin
          done_nxt = 1'b1;
          used_nxt = 1'b0;
          st_nxt   = ST_HEX_EMPTY;
        end else begin
          acc_nxt   = VALUE_WIDTH'(hx.dig);
          phase_nxt = PH_HEX_MORE;
        end
      end
      PH_HEX_MORE: begin
        if (in_end_r || !hx.hit) begin
          fin_val  = 1'b1;
          used_nxt = 1'b0;
        end else begin
          // digits shifted past the top are lost and flagged
          if (acc_r[VALUE_WIDTH-1 -: 4] != 4'd0) ovf_nxt = 1'b1;
          acc_nxt = {acc_r[VALUE_WIDTH-5:0], hx.dig};
        end
      end
      default: ;
    endcase

    // Finished value: range check
    fin_ext = VAL_W'(fin_acc);
    if (fin_val) begin
      done_nxt = 1'b1;
      val_nxt  = fin_ext;
      if (ovf_nxt || fin_ext < range_low_r || fin_ext > range_high_r) begin
        st_nxt = ST_TOO_LARGE;
      end
    end

    // Any finish returns to idle
    if (done_nxt) begin
      phase_nxt = PH_IDLE;
      dcnt_nxt  = 2'd0;
      acc_nxt   = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      phase_r   <= PH_IDLE;
      dcnt_r    <= 2'd0;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) begin
        phase_r <= phase_nxt;
        dcnt_r  <= dcnt_nxt;
        acc_r   <= acc_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      done_r <= done_nxt;
      used_r <= used_nxt;
      val_r  <= val_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_chan.valid    = out_vld_r;
  assign out_chan.done_res = done_r;
  assign out_chan.consumed = used_r;
  assign out_chan.value    = val_r;
  assign out_chan.status   = st_r;

  // Checks
  a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !done_r |-> st_r == ST_OK && val_r == '0)
    else $error("unfinished word carries value or status");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (st_r == ST_HEX_EMPTY || st_r == ST_UNKNOWN ||
                  st_r == ST_UNEXPECTED_END || st_r == ST_UNIVERSAL)
    |-> val_r == '0)
    else $error("error result carries a value");

  a_handback_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !used_r |-> done_r)
    else $error("character handed back without a finished escape");

  a_octal_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_OCTAL |-> dcnt_r == 2'd1 || dcnt_r == 2'd2)
    else $error("octal digit count out of step");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !in_vld_r && phase_r == PH_IDLE)
    else $error("pipeline not empty after reset");

endmodule

/* bench/tb_c_escape_sequence_decoder_unit.sv */
// Testbench for the C escape sequence decoder: directed and random escapes,
// range register settings and output back-pressure, each result checked.
// Depends on ced_pkg, ced_in_if, ced_out_if and c_escape_sequence_decoder_unit.
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder_unit;
  import ced_pkg::*;

  typedef struct packed {
    logic                done_res;
    logic                consumed;
    logic [VAL_W-1:0]    value;
    logic [STATUS_W-1:0] status;
  } decode_t;

  localparam logic [CH_W-1:0] SIMPLE_LETTERS [11] = '{
    CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH,
    CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [VAL_W-1:0] cfg_wdata;

  ced_in_if  in_chan ();
  ced_out_if out_chan ();

  c_escape_sequence_decoder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the decoder state and range registers
  logic [1:0]       esc_phase;
  logic [1:0]       oct_digits;
  logic [VAL_W-1:0] esc_acc;
  logic             esc_ovf;
  logic [VAL_W-1:0] range_lo;
  logic [VAL_W-1:0] range_hi;

  decode_t expected_decodes[$];
  int      mismatches  = 0;
  int      words_sent  = 0;
  int      burst_left  = 0;
  int      hold_left   = 0;
  longint  rx_cycle    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int simple_value(input logic [CH_W-1:0] c);
    case (c)
      CH_QUOTE, CH_DQUOTE, CH_QMARK, CH_BSLASH: return int'(c);
      CH_A: return int'(CODE_BEL);
      CH_B: return int'(CODE_BS);
      CH_F: return int'(CODE_FF);
      CH_N: return int'(CODE_LF);
      CH_R: return int'(CODE_CR);
      CH_T: return int'(CODE_HT);
      CH_V: return int'(CODE_VT);
      default: return -1;
    endcase
  endfunction

  function automatic int hex_value(input logic [CH_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LOW_AA && c <= CH_LOW_FF) return int'(c - CH_LOW_AA) + 10;
    if (c >= CH_UP_AA && c <= CH_UP_FF) return int'(c - CH_UP_AA) + 10;
    return -1;
  endfunction

  function automatic void clear_escape();
    esc_phase  = PH_IDLE;
    oct_digits = 2'd0;
    esc_acc    = '0;
    esc_ovf    = 1'b0;
  endfunction

  // Completed value: range check, then back to idle
  function automatic decode_t close_value(input logic used, input logic [VAL_W-1:0] v);
    decode_t r;
    r.done_res = 1'b1;
    r.consumed = used;
    r.value    = v;
    r.status   = (esc_ovf || v < range_lo || v > range_hi) ? ST_TOO_LARGE : ST_OK;
    clear_escape();
    return r;
  endfunction

  function automatic decode_t close_error(input logic used, input logic [STATUS_W-1:0] st);
    decode_t r;
    r.done_res = 1'b1;
    r.consumed = used;
    r.value    = '0;
    r.status   = st;
    clear_escape();
    return r;
  endfunction

  // Expected result of one character word; advances the predictor state
  function automatic decode_t decode_char(input logic [CH_W-1:0] c, input logic e);
    decode_t      r;
    int           d;
    logic [10:0]  oct;
    logic [35:0]  hx;
    r = '0;
    r.consumed = 1'b1;
    case (esc_phase)
      PH_IDLE: begin
        d = simple_value(c);
        if (e) r = close_error(1'b0, ST_UNEXPECTED_END);
        else if (d >= 0) r = close_value(1'b1, VAL_W'(d));
        else if (c >= CH_0 && c <= CH_7) begin
          esc_acc    = VAL_W'(c - CH_0);
          oct_digits = 2'd1;
          esc_phase  = PH_OCTAL;
        end else if (c == CH_X) esc_phase = PH_HEX_FIRST;
        else if (c == CH_LOW_U || c == CH_UP_U) r = close_error(1'b1, ST_UNIVERSAL);
        else r = close_error(1'b1, ST_UNKNOWN);
      end
      PH_OCTAL: begin
        if (e || c < CH_0 || c > CH_7) r = close_value(1'b0, esc_acc);
        else begin
          oct = {esc_acc[7:0], c[2:0]};
          if (oct > 11'd255) esc_ovf = 1'b1;
          esc_acc    = VAL_W'(oct[7:0]);
          oct_digits = oct_digits + 2'd1;
          if (oct_digits == OCT_MAX_DIG) r = close_value(1'b1, esc_acc);
        end
      end
      PH_HEX_FIRST: begin
        d = e ? -1 : hex_value(c);
        if (d < 0) r = close_error(1'b0, ST_HEX_EMPTY);
        else begin
          esc_acc   = VAL_W'(d);
          esc_phase = PH_HEX_MORE;
        end
      end
      default: begin
        d = e ? -1 : hex_value(c);
        if (d < 0) r = close_value(1'b0, esc_acc);
        else begin
          hx = {esc_acc, 4'(d)};
          if (hx[35:32] != 4'd0) esc_ovf = 1'b1;
          esc_acc = hx[31:0];
        end
      end
    endcase
    return r;
  endfunction

  // Send one character word; bursts with random gaps between them
  task automatic send_word(input logic [CH_W-1:0] c, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid  <= 1'b1;
    in_chan.ch     <= c;
    in_chan.at_end <= e;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_decodes.push_back(decode_char(c, e));
    burst_left--;
    words_sent++;
  endtask

  // Stop sending and let every pending result come out
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_ranges(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_RANGE_LOW;
    cfg_wdata <= lo;
    @(posedge clk);
    range_lo = lo;
    cfg_idx   <= REG_RANGE_HIGH;
    cfg_wdata <= hi;
    @(posedge clk);
    range_hi = hi;
    cfg_we <= 1'b0;
  endtask

  // One escape with random content; mostly well formed, some noise
  task automatic send_random_escape();
    int              kind;
    int              n;
    int              d;
    logic [CH_W-1:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      send_word(CH_W'($urandom), $urandom_range(0, 7) == 0);
    end else if (kind < 35) begin
      send_word(SIMPLE_LETTERS[$urandom_range(0, 10)], 1'b0);
    end else if (kind < 60) begin
      // octal: up to three digits, short ones stopped by end or a non-digit
      n = $urandom_range(1, 3);
      repeat (n) send_word(CH_0 + CH_W'($urandom_range(0, 7)), 1'b0);
      if (n < 3) begin
        if ($urandom_range(0, 2) == 0) send_word(CH_W'($urandom), 1'b1);
        else begin
          do c = CH_W'($urandom); while (c >= CH_0 && c <= CH_7);
          send_word(c, 1'b0);
        end
      end
    end else if (kind < 90) begin
      // hex: mostly short, a few long enough to overflow, some empty
      send_word(CH_X, 1'b0);
      if ($urandom_range(0, 9) == 0) n = 0;
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(5, 11);
      else n = $urandom_range(1, 4);
      repeat (n) begin
        d = $urandom_range(0, 15);
        if (d < 10) c = CH_0 + CH_W'(d);
        else c = ($urandom_range(0, 1) ? CH_LOW_AA : CH_UP_AA) + CH_W'(d - 10);
        send_word(c, 1'b0);
      end
      if ($urandom_range(0, 2) == 0) send_word(CH_W'($urandom), 1'b1);
      else begin
        do c = CH_W'($urandom); while (hex_value(c) >= 0);
        send_word(c, 1'b0);
      end
    end else if (kind < 95) begin
      send_word($urandom_range(0, 1) ? CH_LOW_U : CH_UP_U, 1'b0);
    end else begin
      send_word(CH_W'($urandom), 1'b1);
    end
  endtask

  // Every simple letter, universal names, an unknown letter, end at idle
  task automatic test_simple_escapes();
    foreach (SIMPLE_LETTERS[i]) send_word(SIMPLE_LETTERS[i], 1'b0);
    send_word(CH_LOW_U, 1'b0);
    send_word(CH_UP_U, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
  endtask

  // Three digits over 255, and one digit cut short by end
  task automatic test_octal_escapes();
    repeat (3) send_word(CH_7, 1'b0);
    send_word(CH_0 + 8'd1, 1'b0);
    send_word(8'hA5, 1'b1);
  endtask

  // Empty hex at end, and mixed-case digits stopped by a non-hex word
  task automatic test_hex_escapes();
    send_word(CH_X, 1'b0);
    send_word(8'h5A, 1'b1);
    send_word(CH_X, 1'b0);
    send_word(CH_LOW_AA, 1'b0);
    send_word(CH_UP_FF, 1'b0);
    send_word(8'h3B, 1'b0);
  endtask

  // Range extremes, a narrow window and low above high
  task automatic test_range_checks();
    logic [VAL_W-1:0] lo_set [6] = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'h20, 32'h80, 32'd0};
    logic [VAL_W-1:0] hi_set [6] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'h7E, 32'h40,
                                     32'd255};
    int start;
    foreach (lo_set[i]) begin
      load_ranges(lo_set[i], hi_set[i]);
      start = words_sent;
      while (words_sent - start < 30) send_random_escape();
    end
  endtask

  // Long random stream under changing random ranges
  task automatic test_random_stream();
    int start;
    repeat (5) begin
      if ($urandom_range(0, 1)) load_ranges($urandom_range(0, 'h60), $urandom_range('h40, 'h1FF));
      else load_ranges($urandom, $urandom);
      start = words_sent;
      while (words_sent - start < 100) send_random_escape();
    end
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_output_stall();
    int start;
    load_ranges(32'd0, 32'hFFFF);
    hold_left  = 80;
    burst_left = 60;
    start = words_sent;
    while (words_sent - start < 30) send_random_escape();
  endtask

  // Receiver: long hold when asked, else alternating free and stalled windows
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        case ((rx_cycle / 50) % 3)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 3) != 0);
          default: out_chan.ready <= ($urandom_range(0, 4) < 2);
        endcase
      end
    end
  end

  // Result checker
  decode_t got_word;
  decode_t want_word;
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got_word = {out_chan.done_res, out_chan.consumed, out_chan.value, out_chan.status};
      if (expected_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: done=%0d used=%0d value=%h status=%0d",
                   got_word.done_res, got_word.consumed, got_word.value, got_word.status);
      end else begin
        want_word = expected_decodes.pop_front();
        if (got_word !== want_word) begin
          mismatches++;
          // fields in order done/used/value/status
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                     want_word.done_res, want_word.consumed, want_word.value,
                     want_word.status, got_word.done_res, got_word.consumed,
                     got_word.value, got_word.status);
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= REG_RANGE_LOW;
    cfg_wdata      <= '0;
    in_chan.valid  <= 1'b0;
    in_chan.ch     <= '0;
    in_chan.at_end <= 1'b0;
    range_lo = RANGE_LOW_RST;
    range_hi = RANGE_HIGH_RST;
    clear_escape();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_simple_escapes();
    test_octal_escapes();
    test_hex_escapes();
    test_range_checks();
    test_random_stream();
    test_output_stall();

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0 && expected_decodes.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* c_escape_sequence_decoder_unit.f */
rtl/ced_pkg.sv
rtl/ced_in_if.sv
rtl/ced_out_if.sv
rtl/c_escape_sequence_decoder_unit.sv
bench/tb_c_escape_sequence_decoder_unit.sv
